// File: sv/cmpr_dxt1_pkg.sv
// Shared types and constants for the DXT1 block decoder.
// Depends on nothing; imported by every module of the decoder.
package cmpr_dxt1_pkg;

  // Texel rows in one 4x4 block, and the code of the final row.
  localparam int unsigned RowCount = 4;
  localparam logic [1:0]  LastRow  = 2'd3;

  // Alpha byte of every opaque palette entry.
  localparam logic [7:0]  AlphaOpaque = 8'hFF;

  // Fixed-point reciprocal of three: (m * 171) >> 9 equals m / 3 for m < 512.
  localparam logic [7:0]  RecipThree  = 8'd171;
  localparam int unsigned RecipShift  = 9;

  // One compressed block as it arrives.
  typedef struct packed {
    logic [15:0] end_color_a;
    logic [15:0] end_color_b;
    logic [31:0] index_rows;
  } in_word_t;

  // One decoded texel row.
  typedef struct packed {
    logic [1:0]  row_number;
    logic [31:0] texel_zero;
    logic [31:0] texel_one;
    logic [31:0] texel_two;
    logic [31:0] texel_three;
    logic        last_row;
  } out_word_t;

  // Four ARGB8888 palette entries, entry 0 in the low word.
  typedef logic [3:0][31:0] palette_t;

  // A block ready for row output: its palette and its index bits.
  typedef struct packed {
    palette_t    pal;
    logic [31:0] index_rows;
  } block_t;

endpackage

// File: sv/cmpr_dxt1_block_decoder.sv
// Top level of the DXT1 block decoder: input register, palette logic, row output.
// Depends on cmpr_dxt1_pkg, cmpr_dxt1_palette and cmpr_dxt1_row_out.
//
//   channel  | valid       | stall       | word
//   ---------+-------------+-------------+-----------------------------
//   input    | in_valid_i  | in_stall_o  | in_word_i  (one block)
//   output   | out_valid_o | out_stall_i | out_word_o (one texel row)
//
// Each block gives four row words, one per cycle while the output does not stall.
// A taken block passes the input register, then the block register, and its first row
// word is then loaded into the output register.
// Reset clears all valid flags and the row counter; no clearing pass.
// An output stall holds the row word and backs up into the input stall.
module cmpr_dxt1_block_decoder (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  cmpr_dxt1_pkg::in_word_t  in_word_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  output cmpr_dxt1_pkg::out_word_t out_word_o,
  input  logic                     out_stall_i
);
  import cmpr_dxt1_pkg::*;

  logic     in_valid_q;
  in_word_t in_q;
  logic     blk_free;
  logic     in_take;
  block_t   blk;

  // The input register takes a word when empty or when its word moves on.
  assign in_stall_o = in_valid_q && !blk_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_word_i;
    end
  end

  // Palette from the registered end colors.
  cmpr_dxt1_palette u_palette (
    .end_color_a_i (in_q.end_color_a),
    .end_color_b_i (in_q.end_color_b),
    .pal_o         (blk.pal)
  );

  assign blk.index_rows = in_q.index_rows;

  // Block register and row sequencing.
  cmpr_dxt1_row_out u_row_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_valid_i (in_valid_q),
    .blk_i       (blk),
    .blk_free_o  (blk_free),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// File: sv/cmpr_dxt1_palette.sv
// Builds the four-entry ARGB8888 palette from two RGB565 end colors.
// Depends on cmpr_dxt1_pkg. Purely combinational.
module cmpr_dxt1_palette (
  input  logic [15:0]             end_color_a_i,
  input  logic [15:0]             end_color_b_i,
  output cmpr_dxt1_pkg::palette_t pal_o
);
  import cmpr_dxt1_pkg::*;

  // Replicate the top bits of a 5-bit channel into the low bits.
  function automatic logic [7:0] expand5(input logic [4:0] v);
    expand5 = {v, v[4:2]};
  endfunction

  // Replicate the top bits of a 6-bit channel into the low bits.
  function automatic logic [7:0] expand6(input logic [5:0] v);
    expand6 = {v, v[5:4]};
  endfunction

  // from + (to - from) / 3, with the division truncated toward zero.
  function automatic logic [7:0] third_way(input logic [7:0] from, input logic [7:0] to);
    logic        neg;
    logic [7:0]  mag;
    logic [15:0] prod;
    logic [7:0]  quo;
    neg  = (to < from);
    mag  = neg ? (from - to) : (to - from);
    prod = mag * RecipThree;
    quo  = {1'b0, prod[15:RecipShift]};
    third_way = neg ? (from - quo) : (from + quo);
  endfunction

  // Floor of the mean of two channel values.
  function automatic logic [7:0] midpoint(input logic [7:0] x, input logic [7:0] y);
    logic [8:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    midpoint = sum[8:1];
  endfunction

  logic [7:0] ra, ga, ba, rb, gb, bb;
  logic       four_color;

  // Expand both end colors to eight bits per channel.
  assign ra = expand5(end_color_a_i[15:11]);
  assign ga = expand6(end_color_a_i[10:5]);
  assign ba = expand5(end_color_a_i[4:0]);
  assign rb = expand5(end_color_b_i[15:11]);
  assign gb = expand6(end_color_b_i[10:5]);
  assign bb = expand5(end_color_b_i[4:0]);

  // Equal end colors fall into the three-color mode.
  assign four_color = (end_color_a_i > end_color_b_i);

  // Assemble the palette entries.
  always_comb begin
    pal_o[0] = {AlphaOpaque, ra, ga, ba};
    pal_o[1] = {AlphaOpaque, rb, gb, bb};
    if (four_color) begin
      pal_o[2] = {AlphaOpaque, third_way(ra, rb), third_way(ga, gb), third_way(ba, bb)};
      pal_o[3] = {AlphaOpaque, third_way(rb, ra), third_way(gb, ga), third_way(bb, ba)};
    end else begin
      pal_o[2] = {AlphaOpaque, midpoint(ra, rb), midpoint(ga, gb), midpoint(ba, bb)};
      pal_o[3] = 32'h0000_0000;
    end
  end

endmodule

// File: sv/cmpr_dxt1_row_out.sv
// Holds one decoded block and sends its four texel rows through an output register.
// Depends on cmpr_dxt1_pkg.
module cmpr_dxt1_row_out (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     blk_valid_i,
  input  cmpr_dxt1_pkg::block_t    blk_i,
  output logic                     blk_free_o,
  output logic                     out_valid_o,
  output cmpr_dxt1_pkg::out_word_t out_word_o,
  input  logic                     out_stall_i
);
  import cmpr_dxt1_pkg::*;

  logic       hold_valid_q;
  block_t     hold_q;
  logic [1:0] row_q, row_d;
  logic       out_valid_q, out_valid_d;
  out_word_t  out_q, out_d;
  logic       out_free;
  logic       row_move;
  logic       hold_load;
  logic [7:0] row_bits;

  // The output register can take a row when empty or being drained this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign row_move   = hold_valid_q && out_free;
  assign blk_free_o = !hold_valid_q || (row_move && (row_q == LastRow));
  assign hold_load  = blk_valid_i && blk_free_o;

  // Pick the index byte of the current row; row 0 is the top byte.
  always_comb begin
    unique case (row_q)
      2'd0:    row_bits = hold_q.index_rows[31:24];
      2'd1:    row_bits = hold_q.index_rows[23:16];
      2'd2:    row_bits = hold_q.index_rows[15:8];
      default: row_bits = hold_q.index_rows[7:0];
    endcase
  end

  // Next row counter and output word.
  always_comb begin
    row_d       = row_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (row_move) begin
      row_d             = row_q + 2'd1;
      out_valid_d       = 1'b1;
      out_d.row_number  = row_q;
      out_d.texel_zero  = hold_q.pal[row_bits[7:6]];
      out_d.texel_one   = hold_q.pal[row_bits[5:4]];
      out_d.texel_two   = hold_q.pal[row_bits[3:2]];
      out_d.texel_three = hold_q.pal[row_bits[1:0]];
      out_d.last_row    = (row_q == LastRow);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      row_q        <= 2'd0;
      out_valid_q  <= 1'b0;
    end else begin
      if (hold_load) begin
        hold_valid_q <= 1'b1;
      end else if (blk_free_o) begin
        hold_valid_q <= 1'b0;
      end
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (hold_load) begin
      hold_q <= blk_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: tb/cmpr_dxt1_block_decoder_tb.sv
// Testbench for cmpr_dxt1_block_decoder: directed and random DXT1 blocks,
// checked row by row against a predictor built on cmpr_dxt1_pkg types.
// Depends on cmpr_dxt1_pkg and cmpr_dxt1_block_decoder only.
`timescale 1ns / 1ps

module cmpr_dxt1_block_decoder_tb;
  import cmpr_dxt1_pkg::*;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_word_t  in_word_i   = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_word_t out_word_o;
  logic      out_stall_i = 1'b0;

  // Random idling on both channels is enabled only while this is set.
  logic      idle_on     = 1'b0;
  int        stall_left  = 0;
  int        mismatch_count = 0;

  // Expected row words, oldest first.
  out_word_t expected_rows[$];

  cmpr_dxt1_block_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Expand RGB565 channels to 8 bits by replicating the top bits.
  function automatic int widen5(logic [4:0] v);
    return int'({v, v[4:2]});
  endfunction

  function automatic int widen6(logic [5:0] v);
    return int'({v, v[5:4]});
  endfunction

  // One third of the way from one channel value to the other, truncating toward zero.
  function automatic int third_toward(int from, int to);
    return from + (to - from) / 3;
  endfunction

  function automatic logic [31:0] argb(logic [7:0] alpha, int r, int g, int b);
    return {alpha, r[7:0], g[7:0], b[7:0]};
  endfunction

  // Build the four-entry palette of a block and queue its four row words.
  function automatic void predict_rows(in_word_t blk);
    int          ra, ga, ba, rb, gb, bb;
    logic [31:0] palette [4];
    logic [7:0]  row_bits;
    out_word_t   row;
    ra = widen5(blk.end_color_a[15:11]);
    ga = widen6(blk.end_color_a[10:5]);
    ba = widen5(blk.end_color_a[4:0]);
    rb = widen5(blk.end_color_b[15:11]);
    gb = widen6(blk.end_color_b[10:5]);
    bb = widen5(blk.end_color_b[4:0]);
    palette[0] = argb(AlphaOpaque, ra, ga, ba);
    palette[1] = argb(AlphaOpaque, rb, gb, bb);
    if (blk.end_color_a > blk.end_color_b) begin
      palette[2] = argb(AlphaOpaque, third_toward(ra, rb), third_toward(ga, gb),
                        third_toward(ba, bb));
      palette[3] = argb(AlphaOpaque, third_toward(rb, ra), third_toward(gb, ga),
                        third_toward(bb, ba));
    end else begin
      // Midpoint plus transparent black when the first color is not greater.
      palette[2] = argb(AlphaOpaque, (ra + rb) / 2, (ga + gb) / 2, (ba + bb) / 2);
      palette[3] = '0;
    end
    for (int y = 0; y < RowCount; y++) begin
      row_bits        = blk.index_rows[31 - 8 * y -: 8];
      row.row_number  = 2'(y);
      row.texel_zero  = palette[row_bits[7:6]];
      row.texel_one   = palette[row_bits[5:4]];
      row.texel_two   = palette[row_bits[3:2]];
      row.texel_three = palette[row_bits[1:0]];
      row.last_row    = (2'(y) == LastRow);
      expected_rows.push_back(row);
    end
  endfunction

  // Compare one accepted row word with the oldest expectation.
  task automatic check_row(out_word_t got);
    out_word_t want;
    if (expected_rows.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected row word: row=%0d %h %h %h %h last=%b", got.row_number,
                 got.texel_zero, got.texel_one, got.texel_two, got.texel_three,
                 got.last_row);
      return;
    end
    want = expected_rows.pop_front();
    if (got.row_number !== want.row_number || got.texel_zero !== want.texel_zero ||
        got.texel_one !== want.texel_one || got.texel_two !== want.texel_two ||
        got.texel_three !== want.texel_three || got.last_row !== want.last_row) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("row mismatch: expected row=%0d %h %h %h %h last=%b", want.row_number,
                 want.texel_zero, want.texel_one, want.texel_two, want.texel_three,
                 want.last_row);
        $display("              actual   row=%0d %h %h %h %h last=%b", got.row_number,
                 got.texel_zero, got.texel_one, got.texel_two, got.texel_three,
                 got.last_row);
      end
    end
  endtask

  // Output side: check every row word taken at a clock edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      check_row(out_word_o);
  end

  // Output stall in random bursts.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Send one block and wait until it is taken; valid stays high afterwards.
  task automatic send_block(in_word_t blk);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= blk;
    do @(posedge clk_i); while (in_stall_o);
    predict_rows(blk);
  endtask

  task automatic send_fields(logic [15:0] a, logic [15:0] b, logic [31:0] idx);
    in_word_t blk;
    blk.end_color_a = a;
    blk.end_color_b = b;
    blk.index_rows  = idx;
    send_block(blk);
  endtask

  // Lower valid and wait for every expected row word.
  task automatic drain_rows();
    in_valid_i <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk_i);
  endtask

  // Both palette modes, color extremes, every index code in every texel slot.
  task automatic test_directed_blocks();
    idle_on = 1'b0;
    send_fields(16'hFFFF, 16'h0000, 32'h00000000);
    send_fields(16'hFFFF, 16'h0000, 32'h55555555);
    send_fields(16'hFFFF, 16'h0000, 32'hAAAAAAAA);
    send_fields(16'hFFFF, 16'h0000, 32'hFFFFFFFF);
    send_fields(16'hFFFF, 16'h0000, 32'h1B1B1B1B);
    send_fields(16'hFFFF, 16'h0000, 32'hE4E4E4E4);
    send_fields(16'h0000, 16'hFFFF, 32'h1BE4B14E);
    send_fields(16'h0000, 16'hFFFF, 32'hFFFFFFFF);
    // Equal end colors fall into the midpoint and transparent mode.
    send_fields(16'h1234, 16'h1234, 32'h1B1B1B1B);
    send_fields(16'h0000, 16'h0000, 32'hE4E4E4E4);
    send_fields(16'hFFFF, 16'hFFFF, 32'hFFAA5500);
    // Smallest possible "greater" case.
    send_fields(16'h0001, 16'h0000, 32'h1B1B1B1B);
    // Negative, inexact differences: truncation toward zero differs from floor.
    send_fields(16'hF800, 16'h0821, 32'h1B1B1B1B);
    send_fields(16'hF800, 16'h07E0, 32'hE4E4E4E4);
    send_fields(16'h001F, 16'hF800, 32'h1B1B1B1B);
    send_fields(16'h8410, 16'h7BEF, 32'hC6C6C6C6);
    idle_on = 1'b1;
    send_fields(16'h07FF, 16'hF81F, 32'h1B1B1B1B);
    send_fields(16'hF81F, 16'h07FF, 32'hE4E4E4E4);
    drain_rows();
  endtask

  // Random blocks with idling on both sides; some with equal end colors.
  task automatic test_random_blocks(int count);
    logic [15:0] a;
    logic [15:0] b;
    for (int i = 0; i < count; i++) begin
      // Alternate stretches with and without idling.
      idle_on = ((i % 40) < 28);
      a = 16'($urandom);
      b = ($urandom_range(0, 7) == 0) ? a : 16'($urandom);
      send_fields(a, b, $urandom);
    end
    drain_rows();
  endtask

  // Back-to-back blocks at full rate with no idling at all.
  task automatic test_streaming(int count);
    idle_on = 1'b0;
    for (int i = 0; i < count; i++)
      send_fields(16'($urandom), 16'($urandom), $urandom);
    drain_rows();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_blocks();
    test_random_blocks(122);
    test_streaming(40);
    // Allow for the pipeline latency before looking for stray rows.
    repeat (10) @(posedge clk_i);
    if (expected_rows.size() != 0)
      mismatch_count++;
    if (mismatch_count == 0) begin
      $display("cmpr_dxt1_block_decoder_tb: PASS");
    end else begin
      $display("cmpr_dxt1_block_decoder_tb: FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("cmpr_dxt1_block_decoder_tb: FAIL");
    $finish;
  end

endmodule
